// ===== sv/radial_stick_deadzone_unit_defines.svh =====
// Assertion macros shared by the radial stick dead zone RTL.
`ifndef RADIAL_STICK_DEADZONE_UNIT_DEFINES_SVH
`define RADIAL_STICK_DEADZONE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is low.
`define RSD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsd: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define RSD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsd: next-cycle check failed");

`else

`define RSD_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define RSD_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/rsd_pkg.sv =====
// Constants and register map of the radial stick dead zone unit.
`default_nettype none

package rsd_pkg;

    // Width of the radius registers.
    localparam int RADIUS_W = 16;

    // Configuration bus widths.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register reset values.
    localparam logic [RADIUS_W-1:0] INNER_RESET = 16'd3000;
    localparam logic [RADIUS_W-1:0] OUTER_RESET = 16'd28000;

    // Register byte addresses.
    localparam logic [APB_AW-1:0] ADDR_INNER = 3'd0;
    localparam logic [APB_AW-1:0] ADDR_OUTER = 3'd4;

endpackage

`default_nettype wire

// ===== sv/rsd_if.sv =====
// Stream interfaces for stick samples and direction words.
`default_nettype none

interface rsd_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] stick_x;
    logic signed [SAMPLE_BITS-1:0] stick_y;

    modport source (output valid, output stick_x, output stick_y, input ready);
    modport sink   (input valid, input stick_x, input stick_y, output ready);
endinterface

interface rsd_out_if #(
    parameter int OUT_FRAC_BITS = 15
);
    logic                          valid;
    logic                          ready;
    logic signed [OUT_FRAC_BITS:0] dir_x;
    logic signed [OUT_FRAC_BITS:0] dir_y;

    modport source (output valid, output dir_x, output dir_y, input ready);
    modport sink   (input valid, input dir_x, input dir_y, output ready);
endinterface

`default_nettype wire

// ===== sv/radial_stick_deadzone_unit.sv =====
// Radial stick dead zone unit: scales a stick sample to a Q1.F direction word.
//
// The sample channel (i_stick) carries stick_x and stick_y; a word is taken at
// a rising edge where valid and ready are both high. The result channel (o_dir)
// carries dir_x and dir_y in signed Q1.OUT_FRAC_BITS, truncated toward zero
// and saturated. Inner and outer radius are written over the APB port
// (inner at byte 0, outer at byte 4) and should only change while idle.
//
// From acceptance to the result word a sample passes through two
// magnitude/square stages, one sum stage, one square-root stage per result
// bit, a dead-zone stage, a multiply stage, one restoring-division stage per
// quotient bit, and the output register. One word enters every cycle while
// the receiver is not stalling the output register.
//
// Reset clears every stage valid bit and the output register valid, and
// loads the radii with 3000 and 28000. When the receiver stalls with a word
// in the output register, the whole pipeline holds and i_stick.ready drops;
// nothing is lost or repeated.
`default_nettype none
`include "radial_stick_deadzone_unit_defines.svh"

module radial_stick_deadzone_unit #(
    parameter int SAMPLE_BITS   = 16,
    parameter int OUT_FRAC_BITS = 15
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    rsd_in_if.sink                       i_stick,
    rsd_out_if.source                    o_dir,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [rsd_pkg::APB_AW-1:0]   paddr,
    input  wire  [rsd_pkg::APB_DW-1:0]   pwdata,
    output logic [rsd_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import rsd_pkg::*;

    localparam int S   = SAMPLE_BITS;
    localparam int F   = OUT_FRAC_BITS;
    localparam int VW  = 2 * S;
    localparam int PW  = S + RADIUS_W;
    localparam int RMW = PW + 1;
    localparam int QW  = F + 1;
    localparam int CW  = ((S > RADIUS_W) ? S : RADIUS_W) + 1;

    typedef struct packed {
        logic [S-1:0] mx;
        logic [S-1:0] my;
        logic         nx;
        logic         ny;
    } t_side;

    // Configuration registers.
    logic [RADIUS_W-1:0] r_inner;
    logic [RADIUS_W-1:0] r_outer;

    logic w_en;

    // Stage 1: magnitudes and signs.
    logic  r_s1_vld;
    t_side r_s1_side;
    // Stage 2: squares.
    logic          r_s2_vld;
    t_side         r_s2_side;
    logic [VW-1:0] r_s2_sqx;
    logic [VW-1:0] r_s2_sqy;
    // Square-root stages.
    logic [S:0]    r_rt_vld;
    logic [VW-1:0] r_rt_rem  [0:S];
    logic [S-1:0]  r_rt_root [0:S];
    t_side         r_rt_side [0:S];
    // Dead-zone stage.
    logic                r_rc_vld;
    t_side               r_rc_side;
    logic [RADIUS_W-1:0] r_rc_num;
    logic [RADIUS_W-1:0] r_rc_span;
    logic [S-1:0]        r_rc_len;
    // Division stages (element 0 is the multiply stage).
    logic [QW:0]    r_dv_vld;
    logic [RMW-1:0] r_dv_rx [0:QW];
    logic [RMW-1:0] r_dv_ry [0:QW];
    logic [PW-1:0]  r_dv_d  [0:QW];
    logic [QW-1:0]  r_dv_qx [0:QW];
    logic [QW-1:0]  r_dv_qy [0:QW];
    logic           r_dv_nx [0:QW];
    logic           r_dv_ny [0:QW];
    // Output register.
    logic          r_out_vld;
    logic [QW-1:0] r_out_x;
    logic [QW-1:0] r_out_y;

    // Whole pipeline advances when the output register is free or drained.
    assign w_en          = !r_out_vld || o_dir.ready;
    assign i_stick.ready = w_en;
    assign o_dir.valid   = r_out_vld;
    assign o_dir.dir_x   = r_out_x;
    assign o_dir.dir_y   = r_out_y;

    // APB register file.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner <= INNER_RESET;
            r_outer <= OUTER_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr)
                ADDR_INNER: r_inner <= pwdata[RADIUS_W-1:0];
                ADDR_OUTER: r_outer <= pwdata[RADIUS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr)
            ADDR_INNER: prdata = APB_DW'(r_inner);
            ADDR_OUTER: prdata = APB_DW'(r_outer);
            default:    prdata = '0;
        endcase
    end

    // Valid bits of all stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_rt_vld  <= '0;
            r_rc_vld  <= 1'b0;
            r_dv_vld  <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld  <= i_stick.valid;
            r_s2_vld  <= r_s1_vld;
            r_rt_vld  <= {r_rt_vld[S-1:0], r_s2_vld};
            r_rc_vld  <= r_rt_vld[S];
            r_dv_vld  <= {r_dv_vld[QW-1:0], r_rc_vld};
            r_out_vld <= r_dv_vld[QW];
        end
    end

    // Stages 1 to 3: magnitudes, squares, sum of squares.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_side.nx <= i_stick.stick_x[S-1];
            r_s1_side.ny <= i_stick.stick_y[S-1];
            r_s1_side.mx <= i_stick.stick_x[S-1] ? (S'(0) - i_stick.stick_x) : i_stick.stick_x;
            r_s1_side.my <= i_stick.stick_y[S-1] ? (S'(0) - i_stick.stick_y) : i_stick.stick_y;
            r_s2_side    <= r_s1_side;
            r_s2_sqx     <= VW'(r_s1_side.mx) * VW'(r_s1_side.mx);
            r_s2_sqy     <= VW'(r_s1_side.my) * VW'(r_s1_side.my);
            r_rt_rem[0]  <= r_s2_sqx + r_s2_sqy;
            r_rt_root[0] <= '0;
            r_rt_side[0] <= r_s2_side;
        end
    end

    // Square root, one result bit per stage, most significant first.
    for (genvar k = 1; k <= S; k++) begin : g_rt
        localparam int J = S - k;
        logic [VW:0] w_t;
        logic        w_ge;

        always_comb begin
            w_t  = ({1'b0, {S{1'b0}}, r_rt_root[k-1]} << (J + 1))
                 + ((VW + 1)'(1) << (2 * J));
            w_ge = {1'b0, r_rt_rem[k-1]} >= w_t;
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rt_rem[k]  <= w_ge ? VW'({1'b0, r_rt_rem[k-1]} - w_t) : r_rt_rem[k-1];
                r_rt_root[k] <= w_ge ? (r_rt_root[k-1] | (S'(1) << J)) : r_rt_root[k-1];
                r_rt_side[k] <= r_rt_side[k-1];
            end
        end
    end

    // Dead-zone stage: numerator, span and length for the scale factor.
    // A centered stick divides zero by one; a non-positive span uses 1 / len.
    logic [CW-1:0]       w_len_c;
    logic [CW-1:0]       w_inn_c;
    logic [CW-1:0]       w_out_c;
    logic [CW-1:0]       w_d_c;
    logic [CW-1:0]       w_span_c;
    logic [RADIUS_W-1:0] n_rc_num;
    logic [RADIUS_W-1:0] n_rc_span;
    logic [S-1:0]        n_rc_len;

    always_comb begin
        w_len_c   = CW'(r_rt_root[S]);
        w_inn_c   = CW'(r_inner);
        w_out_c   = CW'(r_outer);
        w_span_c  = w_out_c - w_inn_c;
        w_d_c     = w_len_c - w_inn_c;
        n_rc_num  = '0;
        n_rc_span = RADIUS_W'(1);
        n_rc_len  = S'(1);
        if (w_len_c == '0 || w_len_c <= w_inn_c) begin
            n_rc_num = '0;
        end else if (w_out_c <= w_inn_c) begin
            n_rc_num = RADIUS_W'(1);
            n_rc_len = r_rt_root[S];
        end else begin
            n_rc_num  = (w_d_c > w_span_c) ? w_span_c[RADIUS_W-1:0] : w_d_c[RADIUS_W-1:0];
            n_rc_span = w_span_c[RADIUS_W-1:0];
            n_rc_len  = r_rt_root[S];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rc_side <= r_rt_side[S];
            r_rc_num  <= n_rc_num;
            r_rc_span <= n_rc_span;
            r_rc_len  <= n_rc_len;
        end
    end

    // Multiply stage: dividends and the shared divisor.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_rx[0] <= RMW'(PW'(r_rc_side.mx) * PW'(r_rc_num));
            r_dv_ry[0] <= RMW'(PW'(r_rc_side.my) * PW'(r_rc_num));
            r_dv_d[0]  <= PW'(r_rc_len) * PW'(r_rc_span);
            r_dv_qx[0] <= '0;
            r_dv_qy[0] <= '0;
            r_dv_nx[0] <= r_rc_side.nx;
            r_dv_ny[0] <= r_rc_side.ny;
        end
    end

    // Restoring division, one quotient bit per stage. The quotient never
    // exceeds full scale, so the dividend stays below twice the divisor.
    for (genvar k = 1; k <= QW; k++) begin : g_dv
        logic [RMW-1:0] w_dext;
        logic           w_gx;
        logic           w_gy;

        always_comb begin
            w_dext = RMW'(r_dv_d[k-1]);
            w_gx   = r_dv_rx[k-1] >= w_dext;
            w_gy   = r_dv_ry[k-1] >= w_dext;
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_rx[k] <= (w_gx ? (r_dv_rx[k-1] - w_dext) : r_dv_rx[k-1]) << 1;
                r_dv_ry[k] <= (w_gy ? (r_dv_ry[k-1] - w_dext) : r_dv_ry[k-1]) << 1;
                r_dv_qx[k] <= {r_dv_qx[k-1][QW-2:0], w_gx};
                r_dv_qy[k] <= {r_dv_qy[k-1][QW-2:0], w_gy};
                r_dv_d[k]  <= r_dv_d[k-1];
                r_dv_nx[k] <= r_dv_nx[k-1];
                r_dv_ny[k] <= r_dv_ny[k-1];
            end
        end
    end

    // Sign and saturation into the output register.
    function automatic logic [QW-1:0] f_sat(input logic [QW-1:0] q, input logic neg);
        logic [QW-1:0] full;
        logic [QW-1:0] m;
        full = QW'(1) << F;
        m    = q;
        if (neg) begin
            if (m > full) m = full;
            f_sat = QW'(0) - m;
        end else begin
            if (m > full - QW'(1)) m = full - QW'(1);
            f_sat = m;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_x <= f_sat(r_dv_qx[QW], r_dv_nx[QW]);
            r_out_y <= f_sat(r_dv_qy[QW], r_dv_ny[QW]);
        end
    end

    // Checks on the pipeline's own arithmetic and flow control.
    `RSD_ASSERT_IMP(a_stall_holds_input, i_clk, i_rst_n, (r_out_vld && !o_dir.ready), (!i_stick.ready))
    `RSD_ASSERT_IMP(a_root_floor, i_clk, i_rst_n, r_rt_vld[S], ({1'b0, r_rt_rem[S]} <= ({1'b0, {S{1'b0}}, r_rt_root[S]} << 1)))
    `RSD_ASSERT_IMP(a_div_remainder, i_clk, i_rst_n, r_dv_vld[QW], ((r_dv_rx[QW] < (RMW'(r_dv_d[QW]) << 1)) && (r_dv_ry[QW] < (RMW'(r_dv_d[QW]) << 1))))

endmodule

`default_nettype wire
